// ===== rtl/tdh_pkg.sv =====
// Shared types, codes and sizes for the tile dedupe hash table.
package tdh_pkg;

  // Table size and the widths that follow from it
  localparam int TABLE_ENTRIES = 256;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_OUT_W     = 8;
  localparam int HASH_W        = 32;
  localparam int PAL_W         = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } tdh_status_t;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } tdh_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEDUPE_FLIPS    = 1'b0,
    CFG_DEDUPE_PALETTES = 1'b1
  } tdh_cfg_reg_t;

  // One stored table entry
  typedef struct packed {
    logic [HASH_W-1:0] h_plain;
    logic [HASH_W-1:0] h_x;
    logic [HASH_W-1:0] h_y;
    logic [HASH_W-1:0] h_xy;
    logic [PAL_W-1:0]  pal;
  } tdh_entry_t;

  // Settings broadcast to every cell
  typedef struct packed {
    logic             dedupe_flips;
    logic             dedupe_palettes;
    logic [CNT_W-1:0] count;
  } tdh_ctl_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] key;
    logic [PAL_W-1:0]  pal;
    logic [CNT_W-1:0]  pos;
    logic              hit;
    logic              flip_x;
    logic              flip_y;
    logic              differ;
  } tdh_pkt_t;

  // One result item
  typedef struct packed {
    tdh_status_t          status;
    logic [IDX_OUT_W-1:0] tile_index;
    logic                 flip_x;
    logic                 flip_y;
    logic                 palette_override_valid;
    logic [PAL_W-1:0]     palette_override;
  } tdh_res_t;

endpackage

// ===== rtl/tdh_if.sv =====
// Valid/ready channel interfaces for input items, results and register writes.
interface tdh_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tdh_pkg::HASH_W-1:0]    hash_plain;
  logic [tdh_pkg::HASH_W-1:0]    hash_flip_x;
  logic [tdh_pkg::HASH_W-1:0]    hash_flip_y;
  logic [tdh_pkg::HASH_W-1:0]    hash_flip_xy;
  logic [tdh_pkg::PAL_W-1:0]     tile_palette;

  modport source (output valid, kind, hash_plain, hash_flip_x, hash_flip_y, hash_flip_xy,
                  tile_palette, input ready);
  modport sink   (input valid, kind, hash_plain, hash_flip_x, hash_flip_y, hash_flip_xy,
                  tile_palette, output ready);
endinterface

interface tdh_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [tdh_pkg::IDX_OUT_W-1:0] tile_index;
  logic                          flip_x;
  logic                          flip_y;
  logic                          palette_override_valid;
  logic [tdh_pkg::PAL_W-1:0]     palette_override;

  modport source (output valid, status, tile_index, flip_x, flip_y, palette_override_valid,
                  palette_override, input ready);
  modport sink   (input valid, status, tile_index, flip_x, flip_y, palette_override_valid,
                  palette_override, output ready);
endinterface

interface tdh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tdh_pkg::CFG_IDX_W-1:0]  index;
  logic [tdh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tile_dedupe_hash_table_unit.sv =====
// Tile dedupe hash table top level: control, row of entry cells, result register.
// Works on one item at a time. An insert writes its cell at the transfer. A lookup
// sends a search token down the row of TABLE_ENTRIES cells, one cell per cycle, each
// cell comparing its plain hash and, with flips on, its X, Y and XY hashes at once;
// the token passes every cell whatever the fill level. Either result goes through
// the pending register to the output register; the next item is taken once the result
// has reached it. Register writes are taken at any time but belong to idle periods.
module tile_dedupe_hash_table_unit (
  input  logic      clk,
  input  logic      rst_n,
  tdh_in_if.sink    in_ch,
  tdh_out_if.source out_ch,
  tdh_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PEND = 3'b100
  } state_t;

  localparam int TE    = tdh_pkg::TABLE_ENTRIES;
  localparam int CNT_W = tdh_pkg::CNT_W;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          flips_r, pals_r;
  tdh_pkg::tdh_res_t             pend_r, pend_nxt;
  tdh_pkg::tdh_res_t             out_res_r, out_res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          in_xfer, ins_go, full;
  logic [TE-1:0]                 wr_en;
  tdh_pkg::tdh_entry_t           wr_entry;
  tdh_pkg::tdh_ctl_t             ctl;
  tdh_pkg::tdh_pkt_t             pkt [TE+1];
  tdh_pkg::tdh_pkt_t             tail;
  logic [CNT_W+tdh_pkg::IDX_OUT_W-1:0] cnt_ext, pos_ext;

  // Handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign full         = (count_r >= CNT_W'(TE));
  assign ins_go       = in_xfer && (in_ch.kind == tdh_pkg::KIND_INSERT) && !full;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flips_r <= 1'b0;
      pals_r  <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        tdh_pkg::CFG_DEDUPE_FLIPS:    flips_r <= cfg_ch.data[0];
        tdh_pkg::CFG_DEDUPE_PALETTES: pals_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Broadcast entry and settings to the row
  assign wr_entry = '{h_plain: in_ch.hash_plain, h_x: in_ch.hash_flip_x,
                      h_y: in_ch.hash_flip_y, h_xy: in_ch.hash_flip_xy,
                      pal: in_ch.tile_palette};
  assign ctl      = '{dedupe_flips: flips_r, dedupe_palettes: pals_r, count: count_r};

  // Inject a search token at the head of the row
  always_comb begin
    pkt[0]        = '0;
    pkt[0].valid  = in_xfer && (in_ch.kind == tdh_pkg::KIND_LOOKUP);
    pkt[0].key    = in_ch.hash_plain;
    pkt[0].pal    = in_ch.tile_palette;
  end

  // Row of cells
  for (genvar i = 0; i < TE; i++) begin : g_cell
    assign wr_en[i] = ins_go && (count_r == CNT_W'(i));
    tdh_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en[i]),
      .wr_entry (wr_entry),
      .ctl      (ctl),
      .pkt_i    (pkt[i]),
      .pkt_o    (pkt[i+1])
    );
  end

  assign tail    = pkt[TE];
  assign cnt_ext = {{tdh_pkg::IDX_OUT_W{1'b0}}, count_r};
  assign pos_ext = {{tdh_pkg::IDX_OUT_W{1'b0}}, tail.pos};

  // Sequence: accept, scan, hand the result to the output register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.kind == tdh_pkg::KIND_INSERT) begin
            pend_nxt = '0;
            if (full) begin
              pend_nxt.status = tdh_pkg::ST_FULL;
            end else begin
              pend_nxt.status     = tdh_pkg::ST_OK;
              pend_nxt.tile_index = cnt_ext[tdh_pkg::IDX_OUT_W-1:0];
              count_nxt           = count_r + 1'b1;
            end
            state_nxt = S_PEND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          pend_nxt = '0;
          if (tail.hit) begin
            pend_nxt.status                 = tdh_pkg::ST_OK;
            pend_nxt.tile_index             = pos_ext[tdh_pkg::IDX_OUT_W-1:0];
            pend_nxt.flip_x                 = tail.flip_x;
            pend_nxt.flip_y                 = tail.flip_y;
            pend_nxt.palette_override_valid = tail.differ;
            pend_nxt.palette_override       = tail.differ ? tail.pal : '0;
          end else begin
            pend_nxt.status = tdh_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_res_nxt   = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  // Result channel
  assign out_ch.valid                  = out_valid_r;
  assign out_ch.status                 = out_res_r.status;
  assign out_ch.tile_index             = out_res_r.tile_index;
  assign out_ch.flip_x                 = out_res_r.flip_x;
  assign out_ch.flip_y                 = out_res_r.flip_y;
  assign out_ch.palette_override_valid = out_res_r.palette_override_valid;
  assign out_ch.palette_override       = out_res_r.palette_override;

  // A token leaves the row only during a scan
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == S_SCAN))
    else $error("search token left the row outside a scan");

  // A lookup transfer starts a scan
  a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_ch.kind == tdh_pkg::KIND_LOOKUP)) |=> (state_r == S_SCAN))
    else $error("lookup did not start a scan");

  // The fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TE))
    else $error("entry count beyond table size");

  // A new result only arrives from the pending state
  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PEND))
    else $error("result presented without a pending result");

endmodule

// ===== rtl/tdh_cell.sv =====
// One table cell: holds an entry and checks the passing search token against it.
module tdh_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  tdh_pkg::tdh_entry_t wr_entry,
  input  tdh_pkg::tdh_ctl_t   ctl,
  input  tdh_pkg::tdh_pkt_t   pkt_i,
  output tdh_pkg::tdh_pkt_t   pkt_o
);

  tdh_pkg::tdh_entry_t entry_r;
  tdh_pkg::tdh_pkt_t   pkt_r;
  tdh_pkg::tdh_pkt_t   pkt_nxt;
  logic                active;
  logic                pal_ok;
  logic                m_plain, m_x, m_y, m_xy;

  // Hold the entry written at insert
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  // Compare the key; plain first, then X, Y, XY when flips are enabled
  always_comb begin
    active  = pkt_i.valid && !pkt_i.hit && (pkt_i.pos < ctl.count);
    pal_ok  = (entry_r.pal == pkt_i.pal) || ctl.dedupe_palettes;
    m_plain = pal_ok && (entry_r.h_plain == pkt_i.key);
    m_x     = pal_ok && ctl.dedupe_flips && (entry_r.h_x == pkt_i.key);
    m_y     = pal_ok && ctl.dedupe_flips && (entry_r.h_y == pkt_i.key);
    m_xy    = pal_ok && ctl.dedupe_flips && (entry_r.h_xy == pkt_i.key);
    pkt_nxt = pkt_i;
    if (active) begin
      if (m_plain || m_x || m_y || m_xy) begin
        pkt_nxt.hit    = 1'b1;
        pkt_nxt.differ = (entry_r.pal != pkt_i.pal);
        if (m_plain) begin
          pkt_nxt.flip_x = 1'b0;
          pkt_nxt.flip_y = 1'b0;
        end else if (m_x) begin
          pkt_nxt.flip_x = 1'b1;
          pkt_nxt.flip_y = 1'b0;
        end else if (m_y) begin
          pkt_nxt.flip_x = 1'b0;
          pkt_nxt.flip_y = 1'b1;
        end else begin
          pkt_nxt.flip_x = 1'b1;
          pkt_nxt.flip_y = 1'b1;
        end
      end else begin
        pkt_nxt.pos = pkt_i.pos + 1'b1;
      end
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.valid <= 1'b0;
    end else begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the tile dedupe hash table unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GAP      = 13;
  localparam int PHASE_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int SETTLE_WAIT  = tdh_pkg::TABLE_ENTRIES + 10;

  // One tile request as it goes over the input channel
  typedef struct {
    tdh_pkg::tdh_kind_t         kind;
    logic [tdh_pkg::HASH_W-1:0] h_plain;
    logic [tdh_pkg::HASH_W-1:0] h_x;
    logic [tdh_pkg::HASH_W-1:0] h_y;
    logic [tdh_pkg::HASH_W-1:0] h_xy;
    logic [tdh_pkg::PAL_W-1:0]  pal;
  } tile_req_t;

  logic clk = 1'b0;
  logic rst_n;

  tdh_in_if  in_ch();
  tdh_out_if out_ch();
  tdh_cfg_if cfg_ch();

  tile_dedupe_hash_table_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table contents and settings
  logic [tdh_pkg::HASH_W-1:0] tbl_hash [tdh_pkg::TABLE_ENTRIES][4];
  logic [tdh_pkg::PAL_W-1:0]  tbl_pal  [tdh_pkg::TABLE_ENTRIES];
  int                tbl_fill    = 0;
  bit                mode_flips  = 1'b0;
  bit                mode_pals   = 1'b0;

  tdh_pkg::tdh_res_t pending_results[$];
  int                errors      = 0;
  int                cycle_count = 0;
  int                n_lookup    = 0;
  int                n_hit       = 0;
  int                n_flip_hit  = 0;
  int                n_override  = 0;
  int                n_insert    = 0;
  int                n_full      = 0;
  bit                tx_burst    = 1'b0;
  bit                rx_burst    = 1'b0;

  // Work out the result of one request and update the shadow table
  function automatic tdh_pkg::tdh_res_t lookup_or_insert(tile_req_t req);
    tdh_pkg::tdh_res_t res;
    int       last_slot;
    bit       found;
    res = '0;
    if (req.kind == tdh_pkg::KIND_INSERT) begin
      n_insert++;
      if (tbl_fill >= tdh_pkg::TABLE_ENTRIES) begin
        res.status = tdh_pkg::ST_FULL;
        n_full++;
      end else begin
        tbl_hash[tbl_fill] = '{req.h_plain, req.h_x, req.h_y, req.h_xy};
        tbl_pal[tbl_fill]  = req.pal;
        res.status         = tdh_pkg::ST_OK;
        res.tile_index     = tdh_pkg::IDX_OUT_W'(tbl_fill);
        tbl_fill++;
      end
      return res;
    end
    n_lookup++;
    res.status = tdh_pkg::ST_NOT_FOUND;
    last_slot  = mode_flips ? 3 : 0;
    found      = 1'b0;
    // First entry in order wins; within it plain, X, Y, XY
    for (int c = 0; c < tbl_fill && !found; c++) begin
      for (int s = 0; s <= last_slot && !found; s++) begin
        if (tbl_hash[c][s] == req.h_plain && (tbl_pal[c] == req.pal || mode_pals)) begin
          found          = 1'b1;
          res.status     = tdh_pkg::ST_OK;
          res.tile_index = tdh_pkg::IDX_OUT_W'(c);
          res.flip_x     = s[0];
          res.flip_y     = s[1];
          n_hit++;
          if (s != 0) n_flip_hit++;
          if (tbl_pal[c] != req.pal) begin
            res.palette_override_valid = 1'b1;
            res.palette_override       = req.pal;
            n_override++;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic tile_req_t make_req(tdh_pkg::tdh_kind_t kind,
                                         logic [tdh_pkg::HASH_W-1:0] hp,
                                         logic [tdh_pkg::HASH_W-1:0] hx,
                                         logic [tdh_pkg::HASH_W-1:0] hy,
                                         logic [tdh_pkg::HASH_W-1:0] hxy,
                                         logic [tdh_pkg::PAL_W-1:0] pal);
    tile_req_t req;
    req.kind    = kind;
    req.h_plain = hp;
    req.h_x     = hx;
    req.h_y     = hy;
    req.h_xy    = hxy;
    req.pal     = pal;
    return req;
  endfunction

  // Small set of values so that hashes collide across entries and slots
  function automatic logic [tdh_pkg::HASH_W-1:0] pool_hash(int k);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      4:       return 32'hDEAD_BEEF;
      5:       return 32'h1234_5678;
      6:       return 32'h5555_5555;
      default: return 32'hAAAA_AAAA;
    endcase
  endfunction

  function automatic logic [tdh_pkg::HASH_W-1:0] rand_hash();
    int pick;
    int c;
    pick = $urandom_range(0, 9);
    if (pick < 3) return pool_hash($urandom_range(0, 7));
    if (pick == 3 && tbl_fill > 0) begin
      c = $urandom_range(0, tbl_fill - 1);
      return tbl_hash[c][$urandom_range(0, 3)];
    end
    return $urandom;
  endfunction

  function automatic tile_req_t rand_insert();
    return make_req(tdh_pkg::KIND_INSERT, rand_hash(), rand_hash(), rand_hash(),
                    rand_hash(), tdh_pkg::PAL_W'($urandom_range(0, 7)));
  endfunction

  // Mostly keys taken from stored entries, the rest arbitrary
  function automatic tile_req_t rand_lookup();
    tile_req_t req;
    int        c;
    req = make_req(tdh_pkg::KIND_LOOKUP, rand_hash(), $urandom, $urandom, $urandom,
                   tdh_pkg::PAL_W'($urandom_range(0, 7)));
    if (tbl_fill > 0 && $urandom_range(0, 3) != 0) begin
      c = $urandom_range(0, tbl_fill - 1);
      if ($urandom_range(0, 2) == 0) c = tbl_fill - 1;
      req.h_plain = tbl_hash[c][$urandom_range(0, 3)];
      if ($urandom_range(0, 1) == 0) req.pal = tbl_pal[c];
    end
    return req;
  endfunction

  // Drive one request after a random gap and hold it until the transfer
  task automatic send_item(tile_req_t req);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= req.kind;
    in_ch.hash_plain   <= req.h_plain;
    in_ch.hash_flip_x  <= req.h_x;
    in_ch.hash_flip_y  <= req.h_y;
    in_ch.hash_flip_xy <= req.h_xy;
    in_ch.tile_palette <= req.pal;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(lookup_or_insert(req));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(tdh_pkg::tdh_cfg_reg_t idx, bit val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      tdh_pkg::CFG_DEDUPE_FLIPS:    mode_flips = val;
      tdh_pkg::CFG_DEDUPE_PALETTES: mode_pals  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_mode(bit flips, bit pals);
    drain();
    write_reg(tdh_pkg::CFG_DEDUPE_FLIPS, flips);
    write_reg(tdh_pkg::CFG_DEDUPE_PALETTES, pals);
  endtask

  task automatic run_random_phase(int items, int insert_pct);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < insert_pct) send_item(rand_insert());
      else send_item(rand_lookup());
      // occasionally let the pipeline run dry
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  // Lookups on an empty table must miss
  task automatic test_empty_lookup();
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h0000_0000, '0, '0, '0, 3'd0));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '1, '1, '1, 3'd7));
  endtask

  // Entries with extreme hashes, a repeated hash inside one entry and a repeated key
  task automatic test_insert_entries();
    send_item(make_req(tdh_pkg::KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
                       32'hFFFF_0000, 3'd0));
    send_item(make_req(tdh_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                       32'h0000_0000, 3'd7));
    send_item(make_req(tdh_pkg::KIND_INSERT, 32'h1234_5678, 32'h0000_0000, 32'h1234_5678,
                       32'h9ABC_DEF0, 3'd3));
    send_item(make_req(tdh_pkg::KIND_INSERT, 32'h1234_5678, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                       32'h3C3C_3C3C, 3'd5));
  endtask

  // Plain hash only, palettes must agree
  task automatic test_plain_lookup();
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h0000_0000, '0, '0, '0, 3'd0));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 3'd7));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 3'd0));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h1234_5678, '0, '0, '0, 3'd5));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h9ABC_DEF0, '0, '0, '0, 3'd3));
  endtask

  // Hits on X, Y and XY hashes once flip matching is on
  task automatic test_flip_lookup();
    set_mode(1'b1, 1'b0);
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 3'd0));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h0000_FFFF, '0, '0, '0, 3'd0));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'hFFFF_0000, '0, '0, '0, 3'd0));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h0000_0000, '0, '0, '0, 3'd7));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h9ABC_DEF0, '0, '0, '0, 3'd3));
  endtask

  // Differing palettes accepted and reported as an override
  task automatic test_palette_override();
    set_mode(1'b1, 1'b1);
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h0000_0000, '0, '0, '0, 3'd6));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h1234_5678, '0, '0, '0, 3'd5));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'hA5A5_A5A5, '0, '0, '0, 3'd7));
    send_item(make_req(tdh_pkg::KIND_LOOKUP, 32'h5A5A_5A5A, '0, '0, '0, 3'd0));
  endtask

  task automatic test_random_plain();
    set_mode(1'b0, 1'b0);
    run_random_phase(PHASE_ITEMS, 50);
  endtask

  task automatic test_random_flips();
    set_mode(1'b1, 1'b0);
    run_random_phase(PHASE_ITEMS, 50);
  endtask

  task automatic test_random_palettes();
    set_mode(1'b0, 1'b1);
    run_random_phase(PHASE_ITEMS, 50);
  endtask

  // Fill the table, then inserts must be refused and the last entry still found
  task automatic test_table_full();
    while (tbl_fill < tdh_pkg::TABLE_ENTRIES) send_item(rand_insert());
    send_item(make_req(tdh_pkg::KIND_INSERT, '1, '1, '1, '1, 3'd7));
    send_item(make_req(tdh_pkg::KIND_INSERT, '0, '0, '0, '0, 3'd0));
    send_item(rand_insert());
    send_item(make_req(tdh_pkg::KIND_LOOKUP, tbl_hash[tdh_pkg::TABLE_ENTRIES-1][0],
                       '0, '0, '0, tbl_pal[tdh_pkg::TABLE_ENTRIES-1]));
  endtask

  task automatic test_random_full_table();
    set_mode(1'b1, 1'b1);
    run_random_phase(PHASE_ITEMS, 10);
  endtask

  // Compare one field, X included
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Match every result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    tdh_pkg::tdh_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d, tile_index %0d",
               out_ch.status, out_ch.tile_index);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 8'(want.status), 8'(out_ch.status));
        check_field("tile_index", want.tile_index, out_ch.tile_index);
        check_field("flip_x", 8'(want.flip_x), 8'(out_ch.flip_x));
        check_field("flip_y", 8'(want.flip_y), 8'(out_ch.flip_y));
        check_field("palette_override_valid", 8'(want.palette_override_valid),
                    8'(out_ch.palette_override_valid));
        check_field("palette_override", 8'(want.palette_override),
                    8'(out_ch.palette_override));
      end
    end
  end

  // Result side: stall a random number of cycles before each transfer
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = tdh_pkg::KIND_LOOKUP;
    in_ch.hash_plain   = '0;
    in_ch.hash_flip_x  = '0;
    in_ch.hash_flip_y  = '0;
    in_ch.hash_flip_xy = '0;
    in_ch.tile_palette = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = tdh_pkg::CFG_DEDUPE_FLIPS;
    cfg_ch.data        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_lookup();
    test_insert_entries();
    test_plain_lookup();
    test_flip_lookup();
    test_palette_override();
    test_random_plain();
    test_random_flips();
    test_random_palettes();
    test_table_full();
    test_random_full_table();

    // Hold off until every result is in, then watch for strays
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Ran %0d lookups: %0d hits, %0d on flipped hashes, %0d palette overrides.",
             n_lookup, n_hit, n_flip_hit, n_override);
    $display("Ran %0d inserts: %0d refused on a full table; %0d errors in %0d cycles.",
             n_insert, n_full, errors, cycle_count);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
